[rtl/orderbook_q_learning_trainer_assert.svh]
// Assertion helpers for the order-book Q-learning trainer.
`ifndef ORDERBOOK_Q_LEARNING_TRAINER_ASSERT_SVH
`define ORDERBOOK_Q_LEARNING_TRAINER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define OBQLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define OBQLT_ASSERT_NEVER(lbl, cond, msg) \
  `OBQLT_ASSERT(lbl, !(cond), msg)

`endif

[rtl/obqlt_pkg.sv]
`default_nettype none

package obqlt_pkg;

  localparam int LOOKAHEAD_MAX_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int N_ACTIONS         = 3;
  localparam int N_QENTRIES        = 18;
  localparam int QAW               = 5;

  // Spread scale 10000 bps * 65536 * 2 (sum is twice the mid price).
  localparam logic [30:0] SPREAD_SCALE = 31'd1310720000;
  // Wide test: diff * 10000 * 256 * 2 against Q8.8 threshold times sum.
  localparam logic [22:0] WIDE_SCALE   = 23'd5120000;

  localparam logic [1:0] ACT_1PCT  = 2'd0;
  localparam logic [1:0] ACT_5PCT  = 2'd1;
  localparam logic [1:0] ACT_10PCT = 2'd2;

  localparam logic [1:0] IMB_ASK  = 2'd0;
  localparam logic [1:0] IMB_BAL  = 2'd1;
  localparam logic [1:0] IMB_BID  = 2'd2;

  typedef enum logic [2:0] {
    CFG_SPREAD_THR = 3'd0,
    CFG_IMB_THR    = 3'd1,
    CFG_LEARN_RATE = 3'd2,
    CFG_DISCOUNT   = 3'd3,
    CFG_EXPLORE    = 3'd4,
    CFG_REW_LIMIT  = 3'd5,
    CFG_LOOK_CNT   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] spread_thr;
    logic [15:0] imb_thr;
    logic [16:0] learn_rate;
    logic [16:0] discount;
    logic [16:0] explore_rate;
    logic [30:0] reward_limit;
    logic [4:0]  look_cnt;
  } cfg_t;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    logic        ep;
    logic [32:0] sum;
    logic [31:0] spread;
    logic [2:0]  cls;
    logic [15:0] draw;
    logic [1:0]  ract;
  } tick_t;

  typedef struct packed {
    logic [32:0] sum;
    logic [31:0] spread;
    logic [2:0]  cls;
  } ring_t;

  function automatic logic [18:0] act_impact(input logic [1:0] a);
    logic [18:0] r;
    unique case (a)
      ACT_1PCT: r = 19'd32768;
      ACT_5PCT: r = 19'd163840;
      default:  r = 19'd327680;
    endcase
    return r;
  endfunction

  // 6553600 times the unfilled share in percent.
  function automatic logic [29:0] act_drift_scale(input logic [1:0] a);
    logic [29:0] r;
    unique case (a)
      ACT_1PCT: r = 30'd648806400;
      ACT_5PCT: r = 30'd622592000;
      default:  r = 30'd589824000;
    endcase
    return r;
  endfunction

  function automatic logic [QAW-1:0] q_addr(input logic [2:0] row, input logic [1:0] a);
    return QAW'(row) * QAW'(N_ACTIONS) + QAW'(a);
  endfunction

endpackage

`default_nettype wire

[rtl/obqlt_div.sv]
`default_nettype none

module obqlt_div #(
  parameter int NumW = 64,
  parameter int DenW = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int CW = $clog2(NumW);

  logic            busy_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [NumW-1:0] sh_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, sh_q[NumW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      sh_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[NumW-2:0], ge};
      rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

[rtl/obqlt_fifo.sv]
`default_nettype none

module obqlt_fifo import obqlt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output tick_t data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tick_t         buf_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = cnt_q == CW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= data_i;
  end

endmodule

`default_nettype wire

[rtl/obqlt_front.sv]
`default_nettype none

module obqlt_front import obqlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        episode_start_i,
  input  logic [31:0] bid_price_i,
  input  logic [31:0] ask_price_i,
  input  logic [31:0] bid_volume_i,
  input  logic [31:0] ask_volume_i,
  input  logic [15:0] explore_draw_i,
  input  logic [1:0]  random_action_i,
  output logic        push_o,
  output tick_t       push_data_o,
  input  logic        full_i
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MUL  = 5'b00010,
    F_CMP  = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_e;

  fstate_e st_q;

  logic               ep_q;
  logic [31:0]        bid_q, ask_q, bv_q, av_q;
  logic [15:0]        draw_q;
  logic [1:0]         ract_q;
  logic [32:0]        sum_q;
  logic [63:0]        spn_q;
  logic [54:0]        wl_q;
  logic [48:0]        wr_q;
  logic signed [49:0] inum_q, ilim_q;
  logic [2:0]         cls_q;
  logic [31:0]        spread_q;

  logic [32:0]        sum_c, tot_c;
  logic [31:0]        diff_c;
  logic signed [33:0] dv_c;
  logic               wide_c;
  logic [1:0]         imb_c;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_quot;

  assign sum_c  = {1'b0, bid_q} + {1'b0, ask_q};
  assign tot_c  = {1'b0, bv_q} + {1'b0, av_q};
  assign diff_c = (ask_q > bid_q) ? ask_q - bid_q : '0;
  assign dv_c   = $signed({2'b00, bv_q}) - $signed({2'b00, av_q});

  assign wide_c = (sum_q != '0) && (wl_q > 55'(wr_q));

  always_comb begin
    priority if (inum_q > ilim_q) imb_c = IMB_BID;
    else if (inum_q < -ilim_q)    imb_c = IMB_ASK;
    else                          imb_c = IMB_BAL;
  end

  assign in_ready_o = st_q == F_IDLE;
  assign div_start  = (st_q == F_CMP) && (sum_q != '0);
  assign push_o     = st_q == F_PUSH;

  assign push_data_o = '{ep: ep_q, sum: sum_q, spread: spread_q, cls: cls_q,
                         draw: draw_q, ract: ract_q};

  obqlt_div #(.NumW(64), .DenW(33)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (spn_q),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      unique case (st_q)
        F_IDLE: if (in_valid_i) st_q <= F_MUL;
        F_MUL:  st_q <= F_CMP;
        F_CMP:  st_q <= (sum_q != '0) ? F_DIV : F_PUSH;
        F_DIV:  if (div_done && !div_busy) st_q <= F_PUSH;
        F_PUSH: if (!full_i) st_q <= F_IDLE;
        default: st_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && in_valid_i) begin
      ep_q   <= episode_start_i;
      bid_q  <= bid_price_i;
      ask_q  <= ask_price_i;
      bv_q   <= bid_volume_i;
      av_q   <= ask_volume_i;
      draw_q <= explore_draw_i;
      ract_q <= random_action_i;
    end
    if (st_q == F_MUL) begin
      sum_q  <= sum_c;
      spn_q  <= 64'(diff_c) * 64'(SPREAD_SCALE);
      wl_q   <= 55'(diff_c) * 55'(WIDE_SCALE);
      wr_q   <= 49'(cfg_i.spread_thr) * 49'(sum_c);
      inum_q <= 50'(dv_c) <<< 15;
      ilim_q <= $signed({1'b0, 49'(cfg_i.imb_thr) * 49'(tot_c)});
    end
    if (st_q == F_CMP) begin
      cls_q    <= wide_c ? 3'(imb_c) + 3'd3 : 3'(imb_c);
      spread_q <= '0;
    end
    if (st_q == F_DIV && div_done) spread_q <= div_quot[31:0];
  end

endmodule

`default_nettype wire

[rtl/obqlt_back.sv]
`default_nettype none
`include "orderbook_q_learning_trainer_assert.svh"

module obqlt_back import obqlt_pkg::*; #(
  parameter int LookaheadMax = LOOKAHEAD_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  tick_t              tick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         updated_class_o,
  output logic [1:0]         chosen_action_o,
  output logic               explored_o,
  output logic signed [31:0] clipped_reward_o,
  output logic signed [31:0] new_q_value_o
);

  localparam int Depth = LookaheadMax + 1;
  localparam int AW    = $clog2(Depth);
  localparam int FW    = $clog2(Depth + 1);
  localparam int LW    = $clog2(LookaheadMax + 1);

  typedef enum logic [11:0] {
    B_IDLE  = 12'b000000000001,
    B_STORE = 12'b000000000010,
    B_RDO   = 12'b000000000100,
    B_RDN   = 12'b000000001000,
    B_QRD   = 12'b000000010000,
    B_QWAIT = 12'b000000100000,
    B_ACT   = 12'b000001000000,
    B_MUL   = 12'b000010000000,
    B_DST   = 12'b000100000000,
    B_DIV   = 12'b001000000000,
    B_COST  = 12'b010000000000,
    B_OUT   = 12'b100000000000
  } bstate_e;

  bstate_e st_q;

  // ring and Q storage
  ring_t              rmem [Depth];
  ring_t              rrd_q;
  logic [AW-1:0]      raddr;
  logic               rrd_en;
  logic signed [31:0] qmem [N_QENTRIES];
  logic [N_QENTRIES-1:0] qvalid_q;
  logic signed [31:0] qrd_q;
  logic               qrdv_q;
  logic [QAW-1:0]     qaddr;
  logic signed [31:0] qval;

  logic [AW-1:0]      slot_q, old_q;
  logic [FW-1:0]      fill_q, fill_new;
  logic [LW-1:0]      look;
  tick_t              tk_q;

  logic [32:0]        msum_q;
  logic [31:0]        ospread_q;
  logic [2:0]         ocls_q, ncls_q;
  logic [2:0]         k_q, cap_k_q;
  logic               cap_v_q;
  logic signed [31:0] qrow_q [6];

  logic [1:0]         act_q, greedy_c, act_c;
  logic               expl_q, expl_c;
  logic signed [31:0] qsel_q, next_max_q, best_next_c;
  logic [32:0]        d_q;
  logic [62:0]        dnum_q;
  logic signed [49:0] disc_prod_q;
  logic [63:0]        dq_q;
  logic signed [34:0] term_q;
  logic signed [31:0] reward_q;
  logic               lr_done_q;
  logic signed [52:0] lr_prod_q;

  logic [65:0]        cost_c;
  logic [30:0]        clip_c;
  logic signed [34:0] reward_c, disc_c;
  logic signed [37:0] nq_c;
  logic signed [31:0] nq_sat;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_quot;

  logic               out_valid_q, out_load;
  logic [2:0]         oc_q;
  logic [1:0]         oa_q;
  logic               oe_q;
  logic signed [31:0] or_q, onq_q;

  function automatic logic [2:0] mod6(input logic [2:0] c);
    return (c > 3'd5) ? c - 3'd6 : c;
  endfunction

  // effective lookahead: zero acts as one, clamp to the ring
  always_comb begin
    if (cfg_i.look_cnt == '0)                  look = LW'(1);
    else if (32'(cfg_i.look_cnt) > LookaheadMax) look = LW'(LookaheadMax);
    else                                       look = LW'(cfg_i.look_cnt);
  end

  assign fill_new = (32'(fill_q) == Depth) ? fill_q : fill_q + 1'b1;

  assign pop_o = (st_q == B_IDLE) && !empty_i;

  always_comb begin
    rrd_en = 1'b0;
    raddr  = old_q;
    if (st_q == B_RDO) begin
      rrd_en = 1'b1;
    end else if (st_q == B_RDN) begin
      rrd_en = 1'b1;
      raddr  = (32'(old_q) == Depth - 1) ? '0 : old_q + 1'b1;
    end
  end

  always_comb begin
    if (k_q < 3'd3) qaddr = q_addr(mod6(rrd_q.cls) == ocls_q ? ocls_q : ocls_q, 2'(k_q));
    else            qaddr = q_addr(ncls_q, 2'(k_q - 3'd3));
  end

  assign qval = qrdv_q ? qrd_q : '0;

  // first maximum wins
  always_comb begin
    greedy_c = ACT_1PCT;
    if (qrow_q[1] > qrow_q[0]) greedy_c = ACT_5PCT;
    if (qrow_q[2] > qrow_q[{1'b0, greedy_c}]) greedy_c = ACT_10PCT;
    best_next_c = qrow_q[3];
    if (qrow_q[4] > best_next_c) best_next_c = qrow_q[4];
    if (qrow_q[5] > best_next_c) best_next_c = qrow_q[5];
    expl_c = {1'b0, tk_q.draw} < cfg_i.explore_rate;
    if (expl_c) act_c = (tk_q.ract > ACT_10PCT) ? ACT_10PCT : tk_q.ract;
    else        act_c = greedy_c;
  end

  // reward and TD target
  assign cost_c   = 66'(ospread_q >> 1) + 66'(act_impact(act_q)) + 66'(dq_q);
  assign clip_c   = (cost_c > 66'(cfg_i.reward_limit)) ? cfg_i.reward_limit : 31'(cost_c);
  assign reward_c = -$signed(35'(clip_c));
  assign disc_c   = 35'(disc_prod_q >>> 16);

  assign nq_c = 38'(qsel_q) + 38'(lr_prod_q >>> 16);
  always_comb begin
    if (nq_c > 38'sd2147483647)       nq_sat = 32'sh7fffffff;
    else if (nq_c < -38'sd2147483648) nq_sat = 32'sh80000000;
    else                              nq_sat = 32'(nq_c);
  end

  assign div_start = (st_q == B_DST) && (msum_q != '0);
  assign out_load  = (st_q == B_OUT) && lr_done_q && (!out_valid_q || out_ready_i);

  obqlt_div #(.NumW(64), .DenW(33)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (64'(dnum_q)),
    .den_i   (msum_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      cap_v_q     <= 1'b0;
      lr_done_q   <= 1'b0;
      qvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_v_q <= (st_q == B_QRD);
      if (out_load)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (!empty_i) begin
            if (tick_i.ep) begin
              slot_q <= '0;
              fill_q <= '0;
            end
            st_q <= B_STORE;
          end
        end
        B_STORE: begin
          slot_q <= (32'(slot_q) == Depth - 1) ? '0 : slot_q + 1'b1;
          fill_q <= fill_new;
          st_q   <= (32'(fill_new) <= 32'(look)) ? B_IDLE : B_RDO;
        end
        B_RDO: st_q <= B_RDN;
        B_RDN: begin
          k_q  <= '0;
          st_q <= B_QRD;
        end
        B_QRD: begin
          k_q <= k_q + 1'b1;
          if (k_q == 3'd5) st_q <= B_QWAIT;
        end
        B_QWAIT: st_q <= B_ACT;
        B_ACT:   st_q <= B_MUL;
        B_MUL:   st_q <= B_DST;
        B_DST:   st_q <= (msum_q != '0) ? B_DIV : B_COST;
        B_DIV:   if (div_done) st_q <= B_COST;
        B_COST: begin
          lr_done_q <= 1'b0;
          st_q      <= B_OUT;
        end
        B_OUT: begin
          lr_done_q <= 1'b1;
          if (out_load) begin
            qvalid_q[q_addr(ocls_q, act_q)] <= 1'b1;
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) tk_q <= tick_i;
    if (st_q == B_STORE) begin
      rmem[slot_q] <= '{sum: tk_q.sum, spread: tk_q.spread, cls: tk_q.cls};
      old_q <= (32'(slot_q) >= 32'(look)) ? AW'(32'(slot_q) - 32'(look))
                                          : AW'(32'(slot_q) + Depth - 32'(look));
    end
    if (rrd_en) rrd_q <= rmem[raddr];
    if (st_q == B_RDN) begin
      msum_q    <= rrd_q.sum;
      ospread_q <= rrd_q.spread;
      ocls_q    <= mod6(rrd_q.cls);
    end
    if (st_q == B_QRD && k_q == 3'd0) ncls_q <= mod6(rrd_q.cls);
    if (st_q == B_QRD) begin
      qrd_q   <= qmem[qaddr];
      qrdv_q  <= qvalid_q[qaddr];
      cap_k_q <= k_q;
    end
    for (int i = 0; i < 6; i++) begin
      if (cap_v_q && 32'(cap_k_q) == i) qrow_q[i] <= qval;
    end
    if (st_q == B_ACT) begin
      act_q      <= act_c;
      expl_q     <= expl_c;
      qsel_q     <= qrow_q[{1'b0, act_c}];
      next_max_q <= best_next_c;
      d_q        <= (tk_q.sum > msum_q) ? tk_q.sum - msum_q : msum_q - tk_q.sum;
    end
    if (st_q == B_MUL) begin
      dnum_q      <= 63'(act_drift_scale(act_q)) * 63'(d_q);
      disc_prod_q <= 50'($signed({1'b0, cfg_i.discount})) * 50'(next_max_q);
    end
    if (st_q == B_DST) dq_q <= '0;
    if (st_q == B_DIV && div_done) dq_q <= div_quot;
    if (st_q == B_COST) begin
      reward_q <= 32'(reward_c);
      term_q   <= reward_c + disc_c - 35'(qsel_q);
    end
    if (st_q == B_OUT && !lr_done_q) begin
      lr_prod_q <= 53'($signed({1'b0, cfg_i.learn_rate})) * 53'(term_q);
    end
    if (out_load) begin
      qmem[q_addr(ocls_q, act_q)] <= nq_sat;
      oc_q  <= ocls_q;
      oa_q  <= act_q;
      oe_q  <= expl_q;
      or_q  <= reward_q;
      onq_q <= nq_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign updated_class_o  = oc_q;
  assign chosen_action_o  = oa_q;
  assign explored_o       = oe_q;
  assign clipped_reward_o = or_q;
  assign new_q_value_o    = onq_q;

  `OBQLT_ASSERT_NEVER(a_fill_bound, 32'(fill_q) > Depth, "ring fill past depth")
  `OBQLT_ASSERT(a_div_nonzero, div_start |-> (msum_q != '0) && !div_busy, "bad drift divide")
  `OBQLT_ASSERT(a_div_done_state, div_done |-> st_q == B_DIV, "divide done out of state")
  `OBQLT_ASSERT(a_load_free, out_load |-> !out_valid_q || out_ready_i, "result overwritten")

endmodule

`default_nettype wire

[rtl/orderbook_q_learning_trainer.sv]
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------------
// cfg      | cfg_we_i               | cfg_index_i, cfg_data_i (no wait, no read)
// tick in  | in_valid_i/in_ready_o  | episode_start, bid/ask price+volume, draws
// update   | out_valid_o/out_ready_i| updated_class, chosen_action, explored,
//          |                        | clipped_reward, new_q_value
//
// Front classifies a beat with its 64-step spread divider (skipped when the sum is zero).
// Back only fills the ring with a tick until enough ticks are held, then makes an update
// with its 64-step drift divider (skipped when the old sum is zero).
// Reset (rst_ni, async low) loads register defaults, empties ring and marks Q zero.
// A held result in the output register stalls only the back; the front keeps going
// until the 2-entry queue fills.
`default_nettype none

module orderbook_q_learning_trainer import obqlt_pkg::*; #(
  parameter int LOOKAHEAD_MAX = LOOKAHEAD_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               episode_start_i,
  input  logic [31:0]        bid_price_i,
  input  logic [31:0]        ask_price_i,
  input  logic [31:0]        bid_volume_i,
  input  logic [31:0]        ask_volume_i,
  input  logic [15:0]        explore_draw_i,
  input  logic [1:0]         random_action_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         updated_class_o,
  output logic [1:0]         chosen_action_o,
  output logic               explored_o,
  output logic signed [31:0] clipped_reward_o,
  output logic signed [31:0] new_q_value_o
);

  cfg_t  cfg_q;
  logic  push, full, pop, empty;
  tick_t push_data, pop_data;

  // configuration registers, reset to their defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spread_thr   <= 16'd128;
      cfg_q.imb_thr      <= 16'd10813;
      cfg_q.learn_rate   <= 17'd6554;
      cfg_q.discount     <= 17'd58982;
      cfg_q.explore_rate <= 17'd13107;
      cfg_q.reward_limit <= 31'd6553600;
      cfg_q.look_cnt     <= 5'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPREAD_THR: cfg_q.spread_thr   <= cfg_data_i[15:0];
        CFG_IMB_THR:    cfg_q.imb_thr      <= cfg_data_i[15:0];
        CFG_LEARN_RATE: cfg_q.learn_rate   <= cfg_data_i[16:0];
        CFG_DISCOUNT:   cfg_q.discount     <= cfg_data_i[16:0];
        CFG_EXPLORE:    cfg_q.explore_rate <= cfg_data_i[16:0];
        CFG_REW_LIMIT:  cfg_q.reward_limit <= cfg_data_i;
        CFG_LOOK_CNT:   cfg_q.look_cnt     <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  obqlt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .episode_start_i (episode_start_i),
    .bid_price_i     (bid_price_i),
    .ask_price_i     (ask_price_i),
    .bid_volume_i    (bid_volume_i),
    .ask_volume_i    (ask_volume_i),
    .explore_draw_i  (explore_draw_i),
    .random_action_i (random_action_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  obqlt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  obqlt_back #(.LookaheadMax(LOOKAHEAD_MAX)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (empty),
    .pop_o            (pop),
    .tick_i           (pop_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .updated_class_o  (updated_class_o),
    .chosen_action_o  (chosen_action_o),
    .explored_o       (explored_o),
    .clipped_reward_o (clipped_reward_o),
    .new_q_value_o    (new_q_value_o)
  );

endmodule

`default_nettype wire

[bench/orderbook_q_learning_trainer_checker.sv]
`default_nettype none

module orderbook_q_learning_trainer_checker import obqlt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_o,
  input  logic               episode_start_i,
  input  logic [31:0]        bid_price_i,
  input  logic [31:0]        ask_price_i,
  input  logic [31:0]        bid_volume_i,
  input  logic [31:0]        ask_volume_i,
  input  logic [15:0]        explore_draw_i,
  input  logic [1:0]         random_action_i,
  input  logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [2:0]         updated_class_o,
  input  logic [1:0]         chosen_action_o,
  input  logic               explored_o,
  input  logic signed [31:0] clipped_reward_o,
  input  logic signed [31:0] new_q_value_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_N = LOOKAHEAD_MAX_DEF + 1;

  typedef struct packed {
    logic [2:0]         cls;
    logic [1:0]         act;
    logic               expl;
    logic signed [31:0] reward;
    logic signed [31:0] q;
  } update_t;

  update_t      update_q[$];
  cfg_t         cfg;
  logic signed [31:0] qtab [N_QENTRIES];
  logic [32:0]  r_sum [RING_N];
  logic [31:0]  r_spread [RING_N];
  logic [2:0]   r_cls [RING_N];
  int           wslot, fill;

  assign pending_o = update_q.size();

  function automatic int best_action(int row);
    int b;
    b = 0;
    for (int a = 1; a < N_ACTIONS; a++)
      if (qtab[row*3+a] > qtab[row*3+b]) b = a;
    return b;
  endfunction

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  task automatic learn_tick();
    longint sum, diff, bv, av, num, lim, msum, d, drift, cost, rew, disc, qv, dq, nq;
    logic [31:0] spr;
    int wide, imb, cls, cur, look, old, nxt, oc, nc, act, pct;
    bit expl;
    update_t u;
    if (episode_start_i) begin
      fill = 0;
      wslot = 0;
    end
    sum = longint'(bid_price_i) + longint'(ask_price_i);
    diff = (ask_price_i > bid_price_i) ? longint'(ask_price_i) - longint'(bid_price_i) : 0;
    spr = 0;
    wide = 0;
    if (sum != 0) begin
      spr = 32'((diff * 1310720000) / sum);
      wide = (diff * 5120000 > longint'(cfg.spread_thr) * sum) ? 1 : 0;
    end
    bv = longint'(bid_volume_i);
    av = longint'(ask_volume_i);
    num = (bv - av) * 32768;
    lim = longint'(cfg.imb_thr) * (bv + av);
    imb = 1;
    if (num > lim) imb = 2;
    else if (num < -lim) imb = 0;
    cls = wide * 3 + imb;
    cur = wslot;
    r_sum[cur] = 33'(sum);
    r_spread[cur] = spr;
    r_cls[cur] = 3'(cls);
    wslot = (cur + 1) % RING_N;
    if (fill < RING_N) fill++;
    look = cfg.look_cnt;
    if (look == 0) look = 1;
    if (look > LOOKAHEAD_MAX_DEF) look = LOOKAHEAD_MAX_DEF;
    if (fill < look + 1) return;
    old = (cur + RING_N - look) % RING_N;
    nxt = (old + 1) % RING_N;
    oc = r_cls[old] % 6;
    nc = r_cls[nxt] % 6;
    expl = explore_draw_i < cfg.explore_rate;
    act = expl ? ((random_action_i > 2) ? 2 : int'(random_action_i)) : best_action(oc);
    pct = (act == 0) ? 99 : (act == 1) ? 95 : 90;
    msum = r_sum[old];
    drift = 0;
    if (msum != 0) begin
      d = (sum > msum) ? sum - msum : msum - sum;
      drift = (longint'(6553600) * pct * d) / msum;
    end
    cost = longint'(r_spread[old] >> 1) + ((act == 0) ? 32768 : (act == 1) ? 163840 : 327680)
           + drift;
    if (cost > longint'(cfg.reward_limit)) cost = cfg.reward_limit;
    rew = -cost;
    disc = floor16(longint'(cfg.discount) * longint'(qtab[nc*3+best_action(nc)]));
    qv = qtab[oc*3+act];
    dq = floor16(longint'(cfg.learn_rate) * (rew + disc - qv));
    nq = qv + dq;
    if (nq > 64'sd2147483647) nq = 64'sd2147483647;
    if (nq < -64'sd2147483648) nq = -64'sd2147483648;
    qtab[oc*3+act] = 32'(nq);
    u.cls = 3'(oc);
    u.act = 2'(act);
    u.expl = expl;
    u.reward = 32'(rew);
    u.q = 32'(nq);
    update_q = {update_q, u};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    update_t e;
    if (!rst_ni) begin
      cfg <= '{spread_thr: 16'd128, imb_thr: 16'd10813, learn_rate: 17'd6554,
               discount: 17'd58982, explore_rate: 17'd13107,
               reward_limit: 31'd6553600, look_cnt: 5'd10};
      for (int i = 0; i < N_QENTRIES; i++) qtab[i] = '0;
      wslot = 0;
      fill = 0;
      fail_count_o = 0;
      update_q.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (update_q.size() == 0) begin
          $error("update beat with nothing expected");
          fail_count_o++;
        end else begin
          e = update_q.pop_front();
          if (updated_class_o !== e.cls) begin
            $error("updated_class exp %0d got %0d", e.cls, updated_class_o);
            fail_count_o++;
          end
          if (chosen_action_o !== e.act) begin
            $error("chosen_action exp %0d got %0d", e.act, chosen_action_o);
            fail_count_o++;
          end
          if (explored_o !== e.expl) begin
            $error("explored exp %0d got %0d", e.expl, explored_o);
            fail_count_o++;
          end
          if (clipped_reward_o !== e.reward) begin
            $error("clipped_reward exp %0d got %0d", e.reward, clipped_reward_o);
            fail_count_o++;
          end
          if (new_q_value_o !== e.q) begin
            $error("new_q_value exp %0d got %0d", e.q, new_q_value_o);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) learn_tick();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SPREAD_THR: cfg.spread_thr <= cfg_data_i[15:0];
          CFG_IMB_THR:    cfg.imb_thr <= cfg_data_i[15:0];
          CFG_LEARN_RATE: cfg.learn_rate <= cfg_data_i[16:0];
          CFG_DISCOUNT:   cfg.discount <= cfg_data_i[16:0];
          CFG_EXPLORE:    cfg.explore_rate <= cfg_data_i[16:0];
          CFG_REW_LIMIT:  cfg.reward_limit <= cfg_data_i;
          CFG_LOOK_CNT:   cfg.look_cnt <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[bench/tb_orderbook_q_learning_trainer.sv]
`default_nettype none

module tb_orderbook_q_learning_trainer import obqlt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic episode_start_i = 1'b0;
  logic [31:0] bid_price_i = 32'd1, ask_price_i = 32'd1;
  logic [31:0] bid_volume_i = '0, ask_volume_i = '0;
  logic [15:0] explore_draw_i = '0;
  logic [1:0] random_action_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] updated_class_o;
  logic [1:0] chosen_action_o;
  logic explored_o;
  logic signed [31:0] clipped_reward_o, new_q_value_o;
  int fail_count, pending;

  // idle percentages for sender and receiver in the current phase
  int send_idle_pct, recv_stall_pct;
  // mid-price walk for realistic episodes
  longint unsigned mid;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  orderbook_q_learning_trainer DUT (.*);

  orderbook_q_learning_trainer_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls independently of the sender
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(cfg_idx_e idx, logic [30:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drain: wait until all updates are back, then the back's worst latency.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // One tick beat; valid stays up, payload fixed, until accepted.
  // The front is busy classifying after a beat, so the idle gap
  // after valid drops costs no throughput.
  task automatic send_tick(bit ep, logic [31:0] bp, logic [31:0] ap,
                           logic [31:0] bv, logic [31:0] av,
                           logic [15:0] draw, logic [1:0] ra);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    episode_start_i <= ep;
    bid_price_i <= bp;
    ask_price_i <= ap;
    bid_volume_i <= bv;
    ask_volume_i <= av;
    explore_draw_i <= draw;
    random_action_i <= ra;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Tick around a wandering mid with small spread; mostly well formed.
  task automatic random_tick(bit ep);
    logic [31:0] bp, ap;
    longint unsigned sp;
    if ($urandom_range(19) == 0) begin
      bp = $urandom;
      ap = $urandom;
      if (bp == 0) bp = 1;
      if (ap == 0) ap = 1;
    end else begin
      if ($urandom_range(1)) mid = mid + $urandom_range(200);
      else if (mid > 400) mid = mid - $urandom_range(200);
      sp = $urandom_range(40);
      bp = 32'(mid);
      ap = 32'(mid + sp);
    end
    send_tick(ep, bp, ap,
              ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(5000)),
              ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(5000)),
              16'($urandom), 2'($urandom_range(3)));
  endtask

  initial begin
    mid = 100000;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: short lookahead so updates come early
    write_reg(CFG_LOOK_CNT, 31'd1);
    send_tick(1'b1, 32'd1000, 32'd1010, 32'd0, 32'd0, 16'hFFFF, 2'd0);
    send_tick(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 16'd0, 2'd3);
    send_tick(1'b0, 32'd1, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF, 16'd0, 2'd1);
    // ask below bid
    send_tick(1'b0, 32'd5000, 32'd10, 32'd7, 32'd3, 16'd0, 2'd2);
    send_tick(1'b0, 32'd1, 32'd1, 32'd3, 32'd7, 16'd0, 2'd3);
    send_tick(1'b0, 32'd999, 32'd1000, 32'd100, 32'd100, 16'hFFFF, 2'd0);
    send_tick(1'b1, 32'd2000, 32'd2100, 32'hAAAA5555, 32'h5555AAAA, 16'h5555, 2'd1);
    send_tick(1'b0, 32'hAAAAAAAA, 32'hAAAAAAAB, 32'd1, 32'd2, 16'hAAAA, 2'd2);
    send_tick(1'b0, 32'h55555555, 32'h55555556, 32'd2, 32'd1, 16'd1, 2'd0);
    drain();

    // extremes of the registers, then the opposite extremes
    write_reg(CFG_SPREAD_THR, 31'd0);
    write_reg(CFG_IMB_THR, 31'd32768);
    write_reg(CFG_LEARN_RATE, 31'd65536);
    write_reg(CFG_DISCOUNT, 31'd65536);
    write_reg(CFG_EXPLORE, 31'd65536);
    write_reg(CFG_REW_LIMIT, 31'h7FFFFFFF);
    write_reg(CFG_LOOK_CNT, 31'd0);
    for (int i = 0; i < 8; i++) random_tick(i == 0);
    drain();
    write_reg(CFG_SPREAD_THR, 31'd65535);
    write_reg(CFG_IMB_THR, 31'd0);
    write_reg(CFG_LEARN_RATE, 31'd0);
    write_reg(CFG_DISCOUNT, 31'd0);
    write_reg(CFG_EXPLORE, 31'd0);
    write_reg(CFG_REW_LIMIT, 31'd0);
    write_reg(CFG_LOOK_CNT, 31'd31);   // clamps to the ring maximum
    for (int i = 0; i < 20; i++) random_tick(i == 0);
    drain();

    // random phases with varied settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_reg(CFG_SPREAD_THR, 31'($urandom_range(400)));
      write_reg(CFG_IMB_THR, 31'($urandom_range(32768)));
      write_reg(CFG_LEARN_RATE, 31'($urandom_range(65536)));
      write_reg(CFG_DISCOUNT, 31'($urandom_range(65536)));
      write_reg(CFG_EXPLORE, 31'($urandom_range(65536)));
      write_reg(CFG_REW_LIMIT, ($urandom_range(1)) ? 31'($urandom) : 31'd6553600);
      write_reg(CFG_LOOK_CNT, 31'($urandom_range(1, 16)));
      for (int i = 0; i < 170; i++) begin
        random_tick(i == 0 || $urandom_range(49) == 0);
        // hold off once per phase until all updates are back
        if (i == 80) while (pending != 0) @(posedge clk_i);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_orderbook_q_learning_trainer OK");
    end else begin
      $display("tb_orderbook_q_learning_trainer NOT OK");
    end
    $finish;
  end

  // worst case: 717 beats with both sides idling heavily
  initial begin
    #20ms;
    $display("tb_orderbook_q_learning_trainer NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
